FILE: rtl/i2ccds_pkg.sv
// ----------------------------------------------------------------------------
// i2ccds_pkg
// types, register indexes and the two constant divider tables
// ----------------------------------------------------------------------------
package i2ccds_pkg;

   typedef struct packed {
      logic [12:0] dv;
      logic [6:0]  code;
   } div_entry_type;

   typedef logic [5:0] tab_idx_type;

   localparam logic [0:0]  CSR_TARGET_BITRATE = 1'b0;
   localparam logic [0:0]  CSR_TABLE_SELECT   = 1'b1;

   localparam logic [21:0] BITRATE_RESET = 22'd100000;
   localparam logic [18:0] DELAY_SCALE   = 19'd500000;

   localparam tab_idx_type TAB_A_LAST = 6'd49;
   localparam tab_idx_type TAB_B_LAST = 6'd59;

   localparam div_entry_type TAB_A [0:49] = '{
      '{13'd22, 7'h20}, '{13'd24, 7'h21}, '{13'd26, 7'h22}, '{13'd28, 7'h23},
      '{13'd30, 7'h00}, '{13'd32, 7'h24}, '{13'd36, 7'h25}, '{13'd40, 7'h26},
      '{13'd42, 7'h03}, '{13'd44, 7'h27}, '{13'd48, 7'h28}, '{13'd52, 7'h05},
      '{13'd56, 7'h29}, '{13'd60, 7'h06}, '{13'd64, 7'h2A}, '{13'd72, 7'h2B},
      '{13'd80, 7'h2C}, '{13'd88, 7'h09}, '{13'd96, 7'h2D}, '{13'd104, 7'h0A},
      '{13'd112, 7'h2E}, '{13'd128, 7'h2F}, '{13'd144, 7'h0C}, '{13'd160, 7'h30},
      '{13'd192, 7'h31}, '{13'd224, 7'h32}, '{13'd240, 7'h0F}, '{13'd256, 7'h33},
      '{13'd288, 7'h10}, '{13'd320, 7'h34}, '{13'd384, 7'h35}, '{13'd448, 7'h36},
      '{13'd480, 7'h13}, '{13'd512, 7'h37}, '{13'd576, 7'h14}, '{13'd640, 7'h38},
      '{13'd768, 7'h39}, '{13'd896, 7'h3A}, '{13'd960, 7'h17}, '{13'd1024, 7'h3B},
      '{13'd1152, 7'h18}, '{13'd1280, 7'h3C}, '{13'd1536, 7'h3D},
      '{13'd1792, 7'h3E}, '{13'd1920, 7'h1B}, '{13'd2048, 7'h3F},
      '{13'd2304, 7'h1C}, '{13'd2560, 7'h1D}, '{13'd3072, 7'h1E},
      '{13'd3840, 7'h1F}
   };

   localparam div_entry_type TAB_B [0:59] = '{
      '{13'd20, 7'h00}, '{13'd22, 7'h01}, '{13'd24, 7'h02}, '{13'd26, 7'h03},
      '{13'd28, 7'h04}, '{13'd30, 7'h05}, '{13'd32, 7'h09}, '{13'd34, 7'h06},
      '{13'd36, 7'h0A}, '{13'd40, 7'h07}, '{13'd44, 7'h0C}, '{13'd48, 7'h0D},
      '{13'd52, 7'h43}, '{13'd56, 7'h0E}, '{13'd60, 7'h45}, '{13'd64, 7'h12},
      '{13'd68, 7'h0F}, '{13'd72, 7'h13}, '{13'd80, 7'h14}, '{13'd88, 7'h15},
      '{13'd96, 7'h19}, '{13'd104, 7'h16}, '{13'd112, 7'h1A}, '{13'd128, 7'h17},
      '{13'd136, 7'h4F}, '{13'd144, 7'h1C}, '{13'd160, 7'h1D}, '{13'd176, 7'h55},
      '{13'd192, 7'h1E}, '{13'd208, 7'h56}, '{13'd224, 7'h22}, '{13'd228, 7'h24},
      '{13'd240, 7'h1F}, '{13'd256, 7'h23}, '{13'd288, 7'h5C}, '{13'd320, 7'h25},
      '{13'd384, 7'h26}, '{13'd448, 7'h2A}, '{13'd480, 7'h27}, '{13'd512, 7'h2B},
      '{13'd576, 7'h2C}, '{13'd640, 7'h2D}, '{13'd768, 7'h31}, '{13'd896, 7'h32},
      '{13'd960, 7'h2F}, '{13'd1024, 7'h33}, '{13'd1152, 7'h34},
      '{13'd1280, 7'h35}, '{13'd1536, 7'h36}, '{13'd1792, 7'h3A},
      '{13'd1920, 7'h37}, '{13'd2048, 7'h3B}, '{13'd2304, 7'h3C},
      '{13'd2560, 7'h3D}, '{13'd3072, 7'h3E}, '{13'd3584, 7'h7A},
      '{13'd3840, 7'h3F}, '{13'd4096, 7'h7B}, '{13'd5120, 7'h7D},
      '{13'd6144, 7'h7E}
   };

   function automatic div_entry_type tab_entry(input logic sel, input tab_idx_type idx);
      div_entry_type e;
      if (sel) begin
         if (idx <= TAB_B_LAST) e = TAB_B[idx];
         else e = TAB_B[TAB_B_LAST];
      end else begin
         if (idx <= TAB_A_LAST) e = TAB_A[idx];
         else e = TAB_A[TAB_A_LAST];
      end
      return e;
   endfunction

endpackage

FILE: rtl/i2ccds_serial_div.sv
// ----------------------------------------------------------------------------
// i2ccds_serial_div
// restoring divider, one quotient bit per cycle, a 33-bit quotient
// ----------------------------------------------------------------------------
module i2ccds_serial_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [32:0] num,
   input  logic [31:0] den,
   output logic        done,
   output logic [32:0] quo
);

   logic        busy_ff;
   logic        done_ff;
   logic [5:0]  cnt_ff;
   logic [31:0] den_ff;
   logic [31:0] rem_ff;
   logic [32:0] quo_ff;
   logic [32:0] shifted;
   logic [33:0] diff;

   assign shifted = {rem_ff, quo_ff[32]};
   assign diff    = {1'b0, shifted} - {2'b00, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == 6'd1);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'd33;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= den;
         rem_ff <= 32'd0;
         quo_ff <= num;
      end else if (busy_ff) begin
         if (!diff[33]) begin
            rem_ff <= diff[31:0];
            quo_ff <= {quo_ff[31:0], 1'b1};
         end else begin
            rem_ff <= shifted[31:0];
            quo_ff <= {quo_ff[31:0], 1'b0};
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

FILE: rtl/i2c_clock_divider_select.sv
// ----------------------------------------------------------------------------
// i2c_clock_divider_select
// picks the bus clock divider code and stop delay for a module clock rate
// ----------------------------------------------------------------------------
// the held results are sent again when the rate is unchanged, straight from the check state;
// otherwise they are recomputed: two 33-step serial divisions and a scan of up to 60 entries
// one word in flight: no new word is taken while one is in work;
// the next word is taken the cycle after the result is registered
// reset (synchronous): bit rate 100000, first table, held results and last rate zero
// ----------------------------------------------------------------------------
module i2c_clock_divider_select (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // clock_rate
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // divider_code, actual_divider, stop_delay, zero pad
   output logic        rsp_tuser,   // recomputed
   input  logic        csr_wr_en,
   input  logic [0:0]  csr_index,
   input  logic [21:0] csr_wdata
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_DIV1   = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_MUL    = 3'd4;
   localparam logic [2:0] ST_START2 = 3'd5;
   localparam logic [2:0] ST_DIV2   = 3'd6;
   localparam logic [2:0] ST_OUT    = 3'd7;

   logic [2:0]  state_ff, state_in;
   logic [21:0] bitrate_ff;
   logic        tab_sel_ff;
   logic [31:0] rate_ff, rate_in;
   logic [31:0] last_ff, last_in;
   logic [6:0]  code_ff, code_in;
   logic [12:0] divider_ff, divider_in;
   logic [31:0] delay_ff, delay_in;
   logic        fresh_ff, fresh_in;
   logic [32:0] want_ff, want_in;
   logic [5:0]  idx_ff, idx_in;
   logic [31:0] prod_ff, prod_in;
   logic        rsp_valid_ff;
   logic [55:0] rsp_data_ff;
   logic        rsp_user_ff;

   logic [21:0] bitrate;
   logic [30:0] half;
   logic        div_start;
   logic [32:0] div_num;
   logic [31:0] div_den;
   logic        div_done;
   logic [32:0] div_quo;
   logic        out_load;
   logic [5:0]  idx_last;
   i2ccds_pkg::div_entry_type entry;

   assign bitrate  = (bitrate_ff == 22'd0) ? 22'd1 : bitrate_ff;
   assign half     = (rate_ff[31:1] == 31'd0) ? 31'd1 : rate_ff[31:1];
   assign entry    = i2ccds_pkg::tab_entry(tab_sel_ff, idx_ff);
   assign idx_last = tab_sel_ff ? i2ccds_pkg::TAB_B_LAST : i2ccds_pkg::TAB_A_LAST;
   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);

   assign div_start = ((state_ff == ST_CHECK) && (rate_ff != last_ff))
                   || (state_ff == ST_START2);
   assign div_num = (state_ff == ST_START2)
                  ? ({1'b0, prod_ff} + {2'b00, half} - 33'd1)
                  : ({1'b0, rate_ff} + {11'd0, bitrate} - 33'd1);
   assign div_den = (state_ff == ST_START2) ? {1'b0, half} : {10'd0, bitrate};

   i2ccds_serial_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      state_in   = state_ff;
      rate_in    = rate_ff;
      last_in    = last_ff;
      code_in    = code_ff;
      divider_in = divider_ff;
      delay_in   = delay_ff;
      fresh_in   = fresh_ff;
      want_in    = want_ff;
      idx_in     = idx_ff;
      prod_in    = prod_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               rate_in  = req_tdata;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (rate_ff == last_ff) begin
               fresh_in = 1'b0;
               state_in = ST_OUT;
            end else begin
               fresh_in = 1'b1;
               last_in  = rate_ff;
               state_in = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (div_done) begin
               want_in  = div_quo;
               idx_in   = 6'd0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if ((idx_ff == idx_last) || ({20'd0, entry.dv} >= want_ff)) begin
               code_in    = entry.code;
               divider_in = entry.dv;
               state_in   = ST_MUL;
            end else begin
               idx_in = idx_ff + 6'd1;
            end
         end
         ST_MUL: begin
            prod_in  = 32'(i2ccds_pkg::DELAY_SCALE) * 32'(divider_ff);
            state_in = ST_START2;
         end
         ST_START2: begin
            state_in = ST_DIV2;
         end
         ST_DIV2: begin
            if (div_done) begin
               delay_in = div_quo[31:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_load) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bitrate_ff   <= i2ccds_pkg::BITRATE_RESET;
         tab_sel_ff   <= 1'b0;
         last_ff      <= 32'd0;
         code_ff      <= 7'd0;
         divider_ff   <= 13'd0;
         delay_ff     <= 32'd0;
         fresh_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         last_ff    <= last_in;
         code_ff    <= code_in;
         divider_ff <= divider_in;
         delay_ff   <= delay_in;
         fresh_ff   <= fresh_in;
         if (csr_wr_en) begin
            case (csr_index)
               i2ccds_pkg::CSR_TARGET_BITRATE: bitrate_ff <= csr_wdata;
               i2ccds_pkg::CSR_TABLE_SELECT:   tab_sel_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rate_ff <= rate_in;
      want_ff <= want_in;
      idx_ff  <= idx_in;
      prod_ff <= prod_in;
      if (out_load) begin
         rsp_data_ff <= {4'd0, delay_ff, divider_ff, code_ff};
         rsp_user_ff <= fresh_ff;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

FILE: tb/i2c_clock_divider_select_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_clock_divider_select_tb
// feeds module clock rates to the divider selection block under random stalls
// on both sides and several bit rate and table settings, and checks every
// result word against a predicted table entry, stop delay and recompute flag
// ----------------------------------------------------------------------------
module i2c_clock_divider_select_tb;

   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_WORDS = 112;

   typedef struct packed {
      logic [6:0]  code;
      logic [12:0] divider;
      logic [31:0] delay;
      logic        recomputed;
   } divider_setting_type;

   class divider_scoreboard;
      logic [21:0]         bitrate;
      logic                table_sel;
      logic [31:0]         last_rate;
      divider_setting_type held;
      divider_setting_type pending[$];
      int                  errors;

      function new();
         bitrate = i2ccds_pkg::BITRATE_RESET;
         table_sel = 1'b0;
         last_rate = '0;
         held = '0;
         errors = 0;
      endfunction

      function void write_reg(logic [0:0] index, logic [21:0] value);
         if (index == i2ccds_pkg::CSR_TARGET_BITRATE) begin
            bitrate = value;
         end else begin
            table_sel = value[0];
         end
      endfunction

      function void note_clock_rate(logic [31:0] rate);
         logic [63:0]               br;
         logic [63:0]               want;
         logic [63:0]               half;
         logic [63:0]               delay_us;
         i2ccds_pkg::div_entry_type e;
         int                        k;
         int                        last_idx;
         held.recomputed = 1'b0;
         if (rate != last_rate) begin
            last_rate = rate;
            br = (bitrate == '0) ? 64'd1 : 64'(bitrate);
            want = (64'(rate) + br - 64'd1) / br;
            last_idx = table_sel ? int'(i2ccds_pkg::TAB_B_LAST) : int'(i2ccds_pkg::TAB_A_LAST);
            k = 0;
            e = table_sel ? i2ccds_pkg::TAB_B[0] : i2ccds_pkg::TAB_A[0];
            while (k < last_idx && 64'(e.dv) < want) begin
               k++;
               e = table_sel ? i2ccds_pkg::TAB_B[k] : i2ccds_pkg::TAB_A[k];
            end
            half = 64'(rate >> 1);
            if (half == 64'd0) half = 64'd1;
            delay_us = (64'(i2ccds_pkg::DELAY_SCALE) * 64'(e.dv) + half - 64'd1) / half;
            held.code = e.code;
            held.divider = e.dv;
            held.delay = delay_us[31:0];
            held.recomputed = 1'b1;
         end
         pending.push_back(held);
      endfunction

      function void check_result(logic [55:0] data, logic flag);
         divider_setting_type exp_word;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result word data=%h recomputed=%b",
                     $time, data, flag);
            errors++;
            return;
         end
         exp_word = pending.pop_front();
         if (data[6:0] !== exp_word.code) begin
            $display("%0t: divider_code expected %h actual %h",
                     $time, exp_word.code, data[6:0]);
            errors++;
         end
         if (data[19:7] !== exp_word.divider) begin
            $display("%0t: actual_divider expected %0d actual %0d",
                     $time, exp_word.divider, data[19:7]);
            errors++;
         end
         if (data[51:20] !== exp_word.delay) begin
            $display("%0t: stop_delay expected %0d actual %0d",
                     $time, exp_word.delay, data[51:20]);
            errors++;
         end
         if (flag !== exp_word.recomputed) begin
            $display("%0t: recomputed expected %b actual %b", $time, exp_word.recomputed, flag);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // clock_rate
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;    // divider_code, actual_divider, stop_delay, zero pad
   logic        rsp_tuser;    // recomputed
   logic        csr_wr_en;
   logic [0:0]  csr_index;
   logic [21:0] csr_wdata;

   divider_scoreboard sb = new();
   bit          steady_flow = 1'b0;
   bit          hold_off_pending = 1'b0;
   logic [31:0] last_sent = '0;
   logic [21:0] active_bitrate = i2ccds_pkg::BITRATE_RESET;
   logic        active_table = 1'b0;
   int          quiet_cycles = 0;

   i2c_clock_divider_select dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (csr_wr_en) sb.write_reg(csr_index, csr_wdata);
         if (req_tvalid && req_tready) sb.note_clock_rate(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
         if (csr_wr_en || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("tb: failure");
            $finish;
         end
      end
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      int stall;
      rsp_tready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 11);
         if (hold_off_pending) begin
            stall = HOLD_OFF_CYCLES;
            hold_off_pending = 1'b0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // called and returns at a falling edge
   task automatic send_rate(logic [31:0] rate);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= rate;
      last_sent = rate;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_random_rate();
      int                        pick;
      int                        idx;
      logic [63:0]               br;
      logic [63:0]               r;
      i2ccds_pkg::div_entry_type e;
      br = (active_bitrate == '0) ? 64'd1 : 64'(active_bitrate);
      pick = $urandom_range(0, 9);
      idx = $urandom_range(0, active_table ? int'(i2ccds_pkg::TAB_B_LAST)
                                           : int'(i2ccds_pkg::TAB_A_LAST));
      e = active_table ? i2ccds_pkg::TAB_B[idx] : i2ccds_pkg::TAB_A[idx];
      case (pick)
         0, 1: r = 64'(last_sent);
         2, 3, 4, 5: r = br * 64'(e.dv) + 64'($urandom_range(0, 2)) - 64'd1;
         6, 7: r = br * 64'($urandom_range(1, 7000)) + 64'($urandom_range(0, br[31:0] - 1));
         8: r = 64'($urandom);
         default: r = 64'($urandom_range(0, 5));
      endcase
      if (r > 64'hFFFF_FFFF) r = 64'($urandom);
      send_rate(r[31:0]);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(logic [0:0] index, logic [21:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(logic [21:0] bitrate, logic table_sel);
      settle();
      write_reg(i2ccds_pkg::CSR_TARGET_BITRATE, bitrate);
      write_reg(i2ccds_pkg::CSR_TABLE_SELECT, {21'd0, table_sel});
      active_bitrate = bitrate;
      active_table = table_sel;
   endtask

   initial begin
      logic [21:0] phase_bitrate;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wr_en = 1'b0;
      csr_index = i2ccds_pkg::CSR_TARGET_BITRATE;
      csr_wdata = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero rate right after reset matches the cleared last rate
      send_rate(32'd0);
      send_rate(32'd0);
      send_rate(32'd1);
      send_rate(32'd2);
      send_rate(32'hFFFF_FFFF);
      send_rate(32'hFFFF_FFFF);
      send_rate(32'd66000000);
      send_rate(32'd0);
      send_rate(32'd2200000);
      send_rate(32'd2200001);
      send_rate(32'd3);
      // zero bit rate acts as one
      configure(22'd0, 1'b0);
      send_rate(32'd3840);
      send_rate(32'd3841);
      send_rate(32'd21);
      // register change alone keeps the held results
      configure(22'd3400000, 1'b1);
      send_rate(32'd21);
      send_rate(32'd68000000);
      send_rate(32'hFFFF_FFFF);
      send_rate(32'hAAAA_5555);
      configure(22'd1, 1'b1);
      send_rate(32'd6144);
      send_rate(32'd6145);
      send_rate(32'd5000);
      send_rate(32'h5555_AAAA);

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: phase_bitrate = 22'd1;
            1: phase_bitrate = 22'd3400000;
            2: phase_bitrate = 22'h3F_FFFF;
            3: phase_bitrate = 22'd0;
            4: phase_bitrate = 22'd100000;
            5: phase_bitrate = 22'd400000;
            default: phase_bitrate = 22'($urandom_range(1, 3400000));
         endcase
         configure(phase_bitrate, p[0] ^ p[2]);
         steady_flow = (p == 2 || p == 5);
         if (p == 2) hold_off_pending = 1'b1;
         repeat (PHASE_WORDS) send_random_rate();
      end
      steady_flow = 1'b0;
      settle();

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/i2ccds_pkg.sv
rtl/i2ccds_serial_div.sv
rtl/i2c_clock_divider_select.sv
tb/i2c_clock_divider_select_tb.sv
